### rtl/particle_event_selector_macros.svh
// assertion macros used by the block's checker
`ifndef PARTICLE_EVENT_SELECTOR_MACROS_SVH
`define PARTICLE_EVENT_SELECTOR_MACROS_SVH

// clocked assertion, switched off while reset is low
`define PES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define PES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pes_pkg.sv
// shared types, constants and helpers of the particle event selector
package pes_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_PARTICLES = 16;
    localparam int DEF_MOMENTUM_BITS = 18;

    // particle ids and type table
    localparam int ID_W   = 6;
    localparam int NTYPES = 11;
    localparam int TYPE_W = 4;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    localparam logic [ID_W-1:0] ID_GAMMA = 6'd1;
    localparam logic [ID_W-1:0] ID_RES_A = 6'd3;
    localparam logic [ID_W-1:0] ID_PI0   = 6'd7;
    localparam logic [ID_W-1:0] ID_PIP   = 6'd8;
    localparam logic [ID_W-1:0] ID_PIM   = 6'd9;
    localparam logic [ID_W-1:0] ID_KP    = 6'd11;
    localparam logic [ID_W-1:0] ID_KM    = 6'd12;
    localparam logic [ID_W-1:0] ID_N     = 6'd13;
    localparam logic [ID_W-1:0] ID_P     = 6'd14;
    localparam logic [ID_W-1:0] ID_PBAR  = 6'd15;
    localparam logic [ID_W-1:0] ID_ETA   = 6'd17;
    localparam logic [ID_W-1:0] ID_RES_B = 6'd18;

    localparam logic [TYPE_W-1:0] T_UNK  = 4'd0;
    localparam logic [TYPE_W-1:0] T_GAM  = 4'd1;
    localparam logic [TYPE_W-1:0] T_PIP  = 4'd2;
    localparam logic [TYPE_W-1:0] T_PIM  = 4'd3;
    localparam logic [TYPE_W-1:0] T_PI0  = 4'd4;
    localparam logic [TYPE_W-1:0] T_ETA  = 4'd5;
    localparam logic [TYPE_W-1:0] T_KP   = 4'd6;
    localparam logic [TYPE_W-1:0] T_KM   = 4'd7;
    localparam logic [TYPE_W-1:0] T_P    = 4'd8;
    localparam logic [TYPE_W-1:0] T_PBAR = 4'd9;
    localparam logic [TYPE_W-1:0] T_N    = 4'd10;

    typedef logic [NTYPES-1:0][CNT_W-1:0] t_counts;

    // channel code
    localparam int CODE_W     = 27;
    localparam int CODE_SUM_W = 29;
    localparam logic [CODE_W-1:0] CODE_MAX = 27'h7FF_FFFF;
    localparam int unsigned W_UNK  = 10000000;
    localparam int unsigned W_PBAR = 1000000;
    localparam int unsigned W_N    = 100000;
    localparam int unsigned W_P    = 10000;
    localparam int unsigned W_ETA  = 1000;
    localparam int unsigned W_K    = 100;
    localparam int unsigned W_PI   = 10;

    // topology modes and the channel codes they imply
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_P_PIP_PIM  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_P_PIP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_2PIP_PIM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PIP_PIM_KP = 3'd4;
    localparam logic [CODE_W-1:0] CODE_P_PIP_PIM  = 27'd10020;
    localparam logic [CODE_W-1:0] CODE_P_PIP      = 27'd10010;
    localparam logic [CODE_W-1:0] CODE_2PIP_PIM   = 27'd30;
    localparam logic [CODE_W-1:0] CODE_PIP_PIM_KP = 27'd120;

    // squared mass
    localparam int MSQ_OUT_W = 47;
    localparam int WIDE_W    = 64;
    localparam logic signed [WIDE_W-1:0] MSQ_MAX_WIDE = 64'sh0000_3FFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] MSQ_MIN_WIDE = 64'shFFFF_C000_0000_0000;

    // configuration
    localparam int MASS_W     = 16;
    localparam int KEPT_W     = 30;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 30;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_CHANNEL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WANTED_CHANNEL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_MODE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WANTED_MODE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MASS_LOW       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MASS_HIGH      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_KEPT       = 3'd6;
    localparam logic [MASS_W-1:0] MASS_HIGH_RST = 16'd50000;
    localparam logic [KEPT_W-1:0] MAX_KEPT_RST  = 30'd999999999;

    typedef struct packed {
        logic              check_channel;
        logic [CODE_W-1:0] wanted_channel;
        logic              check_mode;
        logic [MODE_W-1:0] wanted_mode;
        logic [MASS_W-1:0] mass_low;
        logic [MASS_W-1:0] mass_high;
        logic [KEPT_W-1:0] max_kept;
    } t_cfg;

    // result word, keep in bit 0
    typedef struct packed {
        logic                 limit_reached;
        logic [MODE_W-1:0]    mode_found;
        logic [CODE_W-1:0]    channel_code;
        logic [MSQ_OUT_W-1:0] mass_squared;
        logic                 keep;
    } t_result;

    localparam int OUT_TDATA_W      = 80;
    localparam int OUT_KEEP_BIT     = 0;
    localparam int OUT_MSQ_SIGN_BIT = 47;
    localparam int OUT_CODE_LSB     = 48;
    localparam int OUT_MODE_LSB     = 75;

    // event queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // map a particle id onto its counter
    function automatic logic [TYPE_W-1:0] type_of(input logic [ID_W-1:0] id);
        logic [TYPE_W-1:0] t;
        case (id)
            ID_GAMMA: t = T_GAM;
            ID_PI0:   t = T_PI0;
            ID_PIP:   t = T_PIP;
            ID_PIM:   t = T_PIM;
            ID_KP:    t = T_KP;
            ID_KM:    t = T_KM;
            ID_N:     t = T_N;
            ID_P:     t = T_P;
            ID_PBAR:  t = T_PBAR;
            ID_ETA:   t = T_ETA;
            default:  t = T_UNK;
        endcase
        return t;
    endfunction

    // protons, neutrons and two reserved ids stay out of the momentum sum
    function automatic logic no_sum(input logic [ID_W-1:0] id);
        return (id == ID_RES_A) || (id == ID_N) || (id == ID_P) || (id == ID_RES_B);
    endfunction

endpackage

### rtl/pes_queue.sv
// small register queue that decouples event accumulation from evaluation
module pes_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### rtl/pes_front.sv
// front end: takes particles, sums four-momenta and counts types per event
module pes_front #(
    parameter int MAX_PARTICLES = pes_pkg::DEF_MAX_PARTICLES,
    parameter int MOMENTUM_BITS = pes_pkg::DEF_MOMENTUM_BITS,
    parameter int SUM_W         = MOMENTUM_BITS + $clog2(MAX_PARTICLES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pes_pkg::ID_W-1:0]        i_particle_id,
    input  logic signed [MOMENTUM_BITS-1:0] i_mom_x,
    input  logic signed [MOMENTUM_BITS-1:0] i_mom_y,
    input  logic signed [MOMENTUM_BITS-1:0] i_mom_z,
    input  logic signed [MOMENTUM_BITS-1:0] i_energy,
    input  logic                            i_last,
    output logic                            o_ev_valid,
    input  logic                            i_ev_ready,
    output logic [4*SUM_W+pes_pkg::NTYPES*pes_pkg::CNT_W-1:0] o_ev_data
);
    import pes_pkg::*;

    localparam int PCNT_W = $clog2(MAX_PARTICLES + 1);

    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_z, r_sum_e;
    logic signed [SUM_W-1:0] n_sum_x, n_sum_y, n_sum_z, n_sum_e;
    t_counts                 r_cnt, n_cnt;
    logic [PCNT_W-1:0]       r_part_cnt, n_part_cnt;
    logic [TYPE_W-1:0]       id_type;
    logic                    take;
    logic                    accept;

    assign o_ready  = i_ev_ready;
    assign accept   = i_valid && o_ready;
    assign id_type  = type_of(i_particle_id);
    assign take     = (r_part_cnt < PCNT_W'(MAX_PARTICLES));

    // accumulate one particle
    always_comb begin
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_sum_z    = r_sum_z;
        n_sum_e    = r_sum_e;
        n_cnt      = r_cnt;
        n_part_cnt = r_part_cnt;
        if (take) begin
            n_part_cnt = r_part_cnt + 1'b1;
            if (!no_sum(i_particle_id)) begin
                n_sum_x = r_sum_x + SUM_W'(i_mom_x);
                n_sum_y = r_sum_y + SUM_W'(i_mom_y);
                n_sum_z = r_sum_z + SUM_W'(i_mom_z);
                n_sum_e = r_sum_e + SUM_W'(i_energy);
            end
            if (r_cnt[id_type] != CNT_MAX) begin
                n_cnt[id_type] = r_cnt[id_type] + 1'b1;
            end
        end
    end

    // hand the closed event to the queue
    assign o_ev_valid = accept && i_last;
    assign o_ev_data  = {n_sum_e, n_sum_z, n_sum_y, n_sum_x, n_cnt};

    // event accumulators, cleared after the last particle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_sum_z    <= '0;
            r_sum_e    <= '0;
            r_cnt      <= '0;
            r_part_cnt <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_sum_x    <= '0;
                r_sum_y    <= '0;
                r_sum_z    <= '0;
                r_sum_e    <= '0;
                r_cnt      <= '0;
                r_part_cnt <= '0;
            end else begin
                r_sum_x    <= n_sum_x;
                r_sum_y    <= n_sum_y;
                r_sum_z    <= n_sum_z;
                r_sum_e    <= n_sum_e;
                r_cnt      <= n_cnt;
                r_part_cnt <= n_part_cnt;
            end
        end
    end

endmodule

### rtl/pes_back.sv
// back end: mass, channel code, mode and keep decision, four stage pipeline
module pes_back #(
    parameter int SUM_W = pes_pkg::DEF_MOMENTUM_BITS + $clog2(pes_pkg::DEF_MAX_PARTICLES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ev_valid,
    output logic                 o_ev_ready,
    input  logic [4*SUM_W+pes_pkg::NTYPES*pes_pkg::CNT_W-1:0] i_ev_data,
    input  pes_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pes_pkg::t_result     o_result
);
    import pes_pkg::*;

    localparam int SQ_W  = 2 * SUM_W;
    localparam int MSQ_W = SQ_W + 2;
    localparam int CNTS_W = NTYPES * CNT_W;

    // event word fields
    t_counts                 ev_cnt;
    logic signed [SUM_W-1:0] ev_x, ev_y, ev_z, ev_e;

    assign ev_cnt = i_ev_data[CNTS_W-1:0];
    assign ev_x   = i_ev_data[CNTS_W +: SUM_W];
    assign ev_y   = i_ev_data[CNTS_W + SUM_W +: SUM_W];
    assign ev_z   = i_ev_data[CNTS_W + 2*SUM_W +: SUM_W];
    assign ev_e   = i_ev_data[CNTS_W + 3*SUM_W +: SUM_W];

    // stage enables, a stage moves when the one after it has room
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4        = !r_v4 || i_ready;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_ev_ready = en1;
    assign o_valid    = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_ev_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // exact topology match on all counters
    function automatic logic counts_are(input t_counts c, input logic [CNT_W-1:0] pip,
                                        input logic [CNT_W-1:0] pim,
                                        input logic [CNT_W-1:0] kp,
                                        input logic [CNT_W-1:0] p);
        return (c[T_GAM] == '0) && (c[T_PIP] == pip) && (c[T_PIM] == pim) &&
               (c[T_PI0] == '0) && (c[T_ETA] == '0) && (c[T_KP] == kp) &&
               (c[T_KM] == '0) && (c[T_P] == p) && (c[T_PBAR] == '0) &&
               (c[T_N] == '0) && (c[T_UNK] == '0);
    endfunction

    logic [MODE_W-1:0] mode_s0;

    always_comb begin
        if (counts_are(ev_cnt, 5'd1, 5'd1, 5'd0, 5'd1)) begin
            mode_s0 = MODE_P_PIP_PIM;
        end else if (counts_are(ev_cnt, 5'd1, 5'd0, 5'd0, 5'd1)) begin
            mode_s0 = MODE_P_PIP;
        end else if (counts_are(ev_cnt, 5'd2, 5'd1, 5'd0, 5'd0)) begin
            mode_s0 = MODE_2PIP_PIM;
        end else if (counts_are(ev_cnt, 5'd1, 5'd1, 5'd1, 5'd0)) begin
            mode_s0 = MODE_PIP_PIM_KP;
        end else begin
            mode_s0 = MODE_NONE;
        end
    end

    // stage 1: squares, weighted counts, mode
    logic signed [SQ_W-1:0]  r_s1_x2, r_s1_y2, r_s1_z2, r_s1_e2;
    logic [CODE_SUM_W-1:0]   r_s1_code_hi, r_s1_code_lo;
    logic [MODE_W-1:0]       r_s1_mode;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_x2 <= SQ_W'(ev_x) * SQ_W'(ev_x);
            r_s1_y2 <= SQ_W'(ev_y) * SQ_W'(ev_y);
            r_s1_z2 <= SQ_W'(ev_z) * SQ_W'(ev_z);
            r_s1_e2 <= SQ_W'(ev_e) * SQ_W'(ev_e);
            r_s1_code_hi <= CODE_SUM_W'(ev_cnt[T_UNK])  * CODE_SUM_W'(W_UNK) +
                            CODE_SUM_W'(ev_cnt[T_PBAR]) * CODE_SUM_W'(W_PBAR) +
                            CODE_SUM_W'(ev_cnt[T_N])    * CODE_SUM_W'(W_N) +
                            CODE_SUM_W'(ev_cnt[T_P])    * CODE_SUM_W'(W_P);
            r_s1_code_lo <= CODE_SUM_W'(ev_cnt[T_ETA]) * CODE_SUM_W'(W_ETA) +
                            (CODE_SUM_W'(ev_cnt[T_KM]) + CODE_SUM_W'(ev_cnt[T_KP])) *
                            CODE_SUM_W'(W_K) +
                            (CODE_SUM_W'(ev_cnt[T_PIM]) + CODE_SUM_W'(ev_cnt[T_PI0]) +
                             CODE_SUM_W'(ev_cnt[T_PIP])) * CODE_SUM_W'(W_PI) +
                            CODE_SUM_W'(ev_cnt[T_GAM]);
            r_s1_mode <= mode_s0;
        end
    end

    // user keeps configuration static while events are in flight; not enforced
    logic [2*MASS_W-1:0] r_low2, r_high2;

    always_ff @(posedge i_clk) begin
        r_low2  <= (2*MASS_W)'(i_cfg.mass_low) * (2*MASS_W)'(i_cfg.mass_low);
        r_high2 <= (2*MASS_W)'(i_cfg.mass_high) * (2*MASS_W)'(i_cfg.mass_high);
    end

    // stage 2: full squared mass and code sum
    logic signed [MSQ_W-1:0] r_s2_msq;
    logic [CODE_SUM_W-1:0]   r_s2_code;
    logic [MODE_W-1:0]       r_s2_mode;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_msq  <= MSQ_W'(r_s1_e2) - MSQ_W'(r_s1_x2) - MSQ_W'(r_s1_y2) -
                         MSQ_W'(r_s1_z2);
            r_s2_code <= r_s1_code_hi + r_s1_code_lo;
            r_s2_mode <= r_s1_mode;
        end
    end

    // stage 3: saturation, window and cut checks
    logic signed [WIDE_W-1:0] msq_wide;
    logic signed [WIDE_W-1:0] low_wide, high_wide;
    logic [MSQ_OUT_W-1:0]     msq_sat;
    logic [CODE_W-1:0]        code_sat;
    logic                     in_window;
    logic                     chan_ok;
    logic                     mode_ok;

    assign msq_wide  = WIDE_W'(r_s2_msq);
    assign low_wide  = signed'({{(WIDE_W-2*MASS_W){1'b0}}, r_low2});
    assign high_wide = signed'({{(WIDE_W-2*MASS_W){1'b0}}, r_high2});
    assign in_window = !r_s2_msq[MSQ_W-1] && (msq_wide >= low_wide) &&
                       (msq_wide <= high_wide);
    assign code_sat  = (r_s2_code > CODE_SUM_W'(CODE_MAX)) ? CODE_MAX
                                                           : r_s2_code[CODE_W-1:0];
    assign chan_ok   = !i_cfg.check_channel || (code_sat == i_cfg.wanted_channel);
    assign mode_ok   = !i_cfg.check_mode || (r_s2_mode == i_cfg.wanted_mode);

    always_comb begin
        if (msq_wide > MSQ_MAX_WIDE) begin
            msq_sat = MSQ_MAX_WIDE[MSQ_OUT_W-1:0];
        end else if (msq_wide < MSQ_MIN_WIDE) begin
            msq_sat = MSQ_MIN_WIDE[MSQ_OUT_W-1:0];
        end else begin
            msq_sat = msq_wide[MSQ_OUT_W-1:0];
        end
    end

    logic [MSQ_OUT_W-1:0] r_s3_msq;
    logic [CODE_W-1:0]    r_s3_code;
    logic [MODE_W-1:0]    r_s3_mode;
    logic                 r_s3_pass;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_msq  <= msq_sat;
            r_s3_code <= code_sat;
            r_s3_mode <= r_s2_mode;
            r_s3_pass <= in_window && chan_ok && mode_ok;
        end
    end

    // stage 4: kept-event limit and output word
    logic [KEPT_W-1:0] r_kept, n_kept;
    logic              keep_s3;

    assign keep_s3 = r_s3_pass && (r_kept < i_cfg.max_kept);
    assign n_kept  = r_kept + KEPT_W'(keep_s3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
        end else if (en4 && r_v3) begin
            r_kept <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            o_result.keep          <= keep_s3;
            o_result.mass_squared  <= r_s3_msq;
            o_result.channel_code  <= r_s3_code;
            o_result.mode_found    <= r_s3_mode;
            o_result.limit_reached <= (n_kept >= i_cfg.max_kept);
        end
    end

endmodule

### rtl/particle_event_selector.sv
// particle event selector: top level with configuration registers
// Takes one particle per cycle while the event queue has room; one result per event,
// also for one-particle events. A result passes from the event queue through the
// evaluation stages of the back end to o_m_axis_tvalid.
// A stalled result does not stop intake until the two-entry event queue fills.
// Reset (synchronous, active low) clears sums, counts, queue, pipeline, kept count
// and loads the configuration registers with their reset values.
module particle_event_selector #(
    parameter int MAX_PARTICLES = pes_pkg::DEF_MAX_PARTICLES,
    parameter int MOMENTUM_BITS = pes_pkg::DEF_MOMENTUM_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // particle_id, mom_x, mom_y, mom_z, energy, zero pad
    input  logic [((pes_pkg::ID_W + 4*MOMENTUM_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // master side
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // keep, mass_squared, channel_code, mode_found, limit_reached, zero pad
    output logic [pes_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [pes_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pes_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import pes_pkg::*;

    localparam int SUM_W = MOMENTUM_BITS + $clog2(MAX_PARTICLES);
    localparam int EV_W  = 4 * SUM_W + NTYPES * CNT_W;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_channel  <= 1'b0;
            r_cfg.wanted_channel <= '0;
            r_cfg.check_mode     <= 1'b0;
            r_cfg.wanted_mode    <= '0;
            r_cfg.mass_low       <= '0;
            r_cfg.mass_high      <= MASS_HIGH_RST;
            r_cfg.max_kept       <= MAX_KEPT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CHECK_CHANNEL:  r_cfg.check_channel  <= i_cfg_wdata[0];
                CFG_WANTED_CHANNEL: r_cfg.wanted_channel <= i_cfg_wdata[CODE_W-1:0];
                CFG_CHECK_MODE:     r_cfg.check_mode     <= i_cfg_wdata[0];
                CFG_WANTED_MODE:    r_cfg.wanted_mode    <= i_cfg_wdata[MODE_W-1:0];
                CFG_MASS_LOW:       r_cfg.mass_low       <= i_cfg_wdata[MASS_W-1:0];
                CFG_MASS_HIGH:      r_cfg.mass_high      <= i_cfg_wdata[MASS_W-1:0];
                CFG_MAX_KEPT:       r_cfg.max_kept       <= i_cfg_wdata[KEPT_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // input word fields
    logic [ID_W-1:0]                 in_id;
    logic signed [MOMENTUM_BITS-1:0] in_x, in_y, in_z, in_e;

    assign in_id = i_s_axis_tdata[ID_W-1:0];
    assign in_x  = i_s_axis_tdata[ID_W +: MOMENTUM_BITS];
    assign in_y  = i_s_axis_tdata[ID_W + MOMENTUM_BITS +: MOMENTUM_BITS];
    assign in_z  = i_s_axis_tdata[ID_W + 2*MOMENTUM_BITS +: MOMENTUM_BITS];
    assign in_e  = i_s_axis_tdata[ID_W + 3*MOMENTUM_BITS +: MOMENTUM_BITS];

    // front end
    logic            fe_valid, fe_ready;
    logic [EV_W-1:0] fe_data;

    pes_front #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MOMENTUM_BITS (MOMENTUM_BITS),
        .SUM_W         (SUM_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_particle_id (in_id),
        .i_mom_x       (in_x),
        .i_mom_y       (in_y),
        .i_mom_z       (in_z),
        .i_energy      (in_e),
        .i_last        (i_s_axis_tlast),
        .o_ev_valid    (fe_valid),
        .i_ev_ready    (fe_ready),
        .o_ev_data     (fe_data)
    );

    // event queue
    logic            q_valid, q_ready;
    logic [EV_W-1:0] q_data;

    pes_queue #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_data  (fe_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    // back end
    t_result result;

    pes_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (q_valid),
        .o_ev_ready (q_ready),
        .i_ev_data  (q_data),
        .i_cfg      (r_cfg),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, result};

endmodule

### rtl/pes_checker.sv
// port-level checks on the result stream, bound to the top level
`include "particle_event_selector_macros.svh"

module pes_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_tvalid,
    input logic                            i_out_tready,
    input logic [pes_pkg::OUT_TDATA_W-1:0] i_out_tdata
);
    import pes_pkg::*;

    logic              keep;
    logic              msq_neg;
    logic [CODE_W-1:0] code;
    logic [MODE_W-1:0] mode;

    assign keep    = i_out_tdata[OUT_KEEP_BIT];
    assign msq_neg = i_out_tdata[OUT_MSQ_SIGN_BIT];
    assign code    = i_out_tdata[OUT_CODE_LSB +: CODE_W];
    assign mode    = i_out_tdata[OUT_MODE_LSB +: MODE_W];

    // nothing comes out of a block held in reset
    `PES_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_tvalid, "result during reset")

    // a stalled result word holds
    `PES_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_tvalid && !i_out_tready |=> i_out_tvalid && $stable(i_out_tdata), "stalled result changed")

    // a kept event never has a negative squared mass
    `PES_ASSERT(a_keep_mass, i_clk, i_rst_n, i_out_tvalid && keep |-> !msq_neg, "kept event with negative mass squared")

    // a recognized topology fixes the channel code
    `PES_ASSERT(a_mode_code, i_clk, i_rst_n, i_out_tvalid && (mode != MODE_NONE) |-> (mode == MODE_P_PIP_PIM && code == CODE_P_PIP_PIM) || (mode == MODE_P_PIP && code == CODE_P_PIP) || (mode == MODE_2PIP_PIM && code == CODE_2PIP_PIM) || (mode == MODE_PIP_PIM_KP && code == CODE_PIP_PIM_KP), "mode and channel code disagree")

endmodule

bind particle_event_selector pes_checker u_pes_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata)
);
